// ----- hdl/deaa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// deaa_pkg
// Shared types, constants and helpers of the double-ended arena allocator.
// ----------------------------------------------------------------------------
package deaa_pkg;

   // sizing
   localparam int MARK_DEPTH = 16;
   localparam int ADDR_BITS  = 32;
   localparam int CNT_W      = $clog2(MARK_DEPTH + 1);
   localparam int IDX_W      = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
   localparam int RAM_DEPTH  = 2 * (2 ** IDX_W);
   localparam int RAM_AW     = IDX_W + 1;
   localparam int ALIGN_W    = 17;
   localparam int CSR_ADDR_W = 4;

   // register reset values
   localparam logic [31:0] RST_BASE   = 32'd0;
   localparam logic [31:0] RST_SIZE   = 32'd65536;
   localparam logic [11:0] RST_HEADER = 12'd64;
   localparam logic [7:0]  RST_MARK   = 8'd16;

   // arena state right after reset
   localparam logic [ADDR_BITS-1:0] RST_LOW_ADDR =
      ADDR_BITS'(ADDR_BITS'(RST_BASE) + ADDR_BITS'(RST_HEADER));
   localparam logic [ADDR_BITS-1:0] RST_HIGH_ADDR =
      ADDR_BITS'(ADDR_BITS'(RST_BASE) + ADDR_BITS'(RST_SIZE) - ADDR_BITS'(1));
   localparam logic [31:0] RST_FREE =
      (RST_SIZE >= 32'(RST_HEADER)) ? (RST_SIZE - 32'(RST_HEADER)) : 32'd0;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_PUSH    = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_CHECK   = 2'd3
   } deaa_mode_type;

   typedef enum logic [1:0] {
      STAT_DONE       = 2'd0,
      STAT_NO_SPACE   = 2'd1,
      STAT_STACK_FULL = 2'd2
   } deaa_status_type;

   typedef enum logic [1:0] {
      REG_ARENA_BASE  = 2'd0,
      REG_ARENA_SIZE  = 2'd1,
      REG_HEADER      = 2'd2,
      REG_MARK        = 2'd3
   } deaa_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ALIGN,
      ST_COMMIT,
      ST_REPORT
   } deaa_state_type;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] size;
      logic [11:0] header;
      logic [7:0]  mark;
   } deaa_cfg_type;

   typedef struct packed {
      logic load;
      logic step_fetch;
      logic step_align;
      logic step_commit;
      logic step_report;
   } deaa_ctrl_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [31:0]          used;
   } deaa_mark_type;

   localparam int MARK_W = $bits(deaa_mark_type);

   function automatic logic [31:0] sat_add32(input logic [31:0] x, input logic [31:0] y);
      logic [32:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage
`default_nettype wire

// ----- hdl/deaa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// deaa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module deaa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- hdl/deaa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// deaa_ctrl
// Request sequencer: fetch, align, commit and report steps of one request.
// ----------------------------------------------------------------------------
module deaa_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output      logic                    busy,
   output      deaa_pkg::deaa_ctrl_type ctrl
);
   import deaa_pkg::*;

   deaa_state_type state_ff;
   deaa_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_ALIGN;
         ST_ALIGN:  state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_REPORT;
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy             = 1'b1;
      ctrl.load        = 1'b0;
      ctrl.step_fetch  = 1'b0;
      ctrl.step_align  = 1'b0;
      ctrl.step_commit = 1'b0;
      ctrl.step_report = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         ST_FETCH:  ctrl.step_fetch  = 1'b1;
         ST_ALIGN:  ctrl.step_align  = 1'b1;
         ST_COMMIT: ctrl.step_commit = 1'b1;
         ST_REPORT: ctrl.step_report = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/deaa_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// deaa_datapath
// Arena pointers and byte counts, alignment arithmetic and the mark stacks.
// ----------------------------------------------------------------------------
module deaa_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire deaa_pkg::deaa_ctrl_type ctrl,
   input  wire deaa_pkg::deaa_cfg_type  cfg,
   input  wire logic [1:0]              req_mode,
   input  wire logic                    req_high_side,
   input  wire logic [16:0]             req_align_bytes,
   input  wire logic [31:0]             req_size_bytes,
   output      logic                    rsp_valid,
   output      logic [1:0]              rsp_status,
   output      logic [31:0]             rsp_address,
   output      logic [31:0]             rsp_remaining,
   output      logic                    rsp_all_free
);
   import deaa_pkg::*;

   // arena state
   logic [ADDR_BITS-1:0] low_addr_ff, low_addr_in;
   logic [ADDR_BITS-1:0] high_addr_ff, high_addr_in;
   logic [31:0]          free_ff, free_in;
   logic [31:0]          low_used_ff, low_used_in;
   logic [31:0]          high_used_ff, high_used_in;
   logic [CNT_W-1:0]     low_cnt_ff, low_cnt_in;
   logic [CNT_W-1:0]     high_cnt_ff, high_cnt_in;

   // arena start values, tracked from the registers
   logic [ADDR_BITS-1:0] init_low_ff, init_low_in;
   logic [ADDR_BITS-1:0] init_high_ff, init_high_in;
   logic [31:0]          init_free_ff, init_free_in;

   // request beat
   deaa_mode_type        mode_ff, mode_in;
   logic                 side_ff, side_in;
   logic [ALIGN_W-1:0]   align_ff, align_in;
   logic [31:0]          size_ff, size_in;

   // fetch step results
   logic [31:0]          teff_ff, teff_in;
   logic [ALIGN_W-1:0]   mask_ff, mask_in;
   logic                 fits_ff, fits_in;
   logic [ADDR_BITS-1:0] q_ff, q_in;
   logic [ALIGN_W-1:0]   s_ff, s_in;

   // align step results
   logic [ADDR_BITS-1:0] pal_ff, pal_in;
   logic [32:0]          tot_ff, tot_in;
   logic [ADDR_BITS-1:0] ent_addr_ff, ent_addr_in;
   logic [31:0]          ent_used_ff, ent_used_in;
   logic [31:0]          gain_ff, gain_in;

   // commit step results
   deaa_status_type      status_ff, status_in;
   logic [31:0]          addr_ff, addr_in;

   // response
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_address_ff, rsp_address_in;
   logic [31:0]          rsp_remaining_ff, rsp_remaining_in;
   logic                 rsp_all_free_ff, rsp_all_free_in;

   // stack ram
   logic                 ram_wr_en;
   logic [RAM_AW-1:0]    ram_wr_addr;
   deaa_mark_type        ram_wr_data;
   logic [RAM_AW-1:0]    ram_rd_addr;
   deaa_mark_type        ram_rd_data;

   // shared views
   logic [CNT_W-1:0]     cnt_sel;
   logic [31:0]          used_sel;
   logic                 cnt_zero;
   logic                 cnt_full;

   // fetch step terms
   logic [31:0]          t_eff;
   logic [ALIGN_W-1:0]   am1;
   logic [32:0]          need;

   // align step terms
   logic [ALIGN_W-1:0]   off;

   assign cnt_sel  = side_ff ? high_cnt_ff : low_cnt_ff;
   assign used_sel = side_ff ? high_used_ff : low_used_ff;
   assign cnt_zero = (cnt_sel == '0);
   assign cnt_full = (cnt_sel >= CNT_W'(MARK_DEPTH));

   assign ram_rd_addr = {side_ff, IDX_W'(cnt_sel - CNT_W'(1))};
   assign ram_wr_addr = {side_ff, IDX_W'(cnt_sel)};
   assign ram_wr_data = '{addr: pal_ff, used: used_sel};
   assign ram_wr_en   = ctrl.step_commit && (mode_ff == MODE_PUSH) && !cnt_full && fits_ff;

   deaa_ram #(
      .WIDTH (MARK_W),
      .DEPTH (RAM_DEPTH)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ctrl.step_fetch),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      init_low_in  = ADDR_BITS'(ADDR_BITS'(cfg.base) + ADDR_BITS'(cfg.header));
      init_high_in = ADDR_BITS'(ADDR_BITS'(cfg.base) + ADDR_BITS'(cfg.size) - ADDR_BITS'(1));
      init_free_in = (cfg.size >= 32'(cfg.header)) ? (cfg.size - 32'(cfg.header)) : 32'd0;
   end

   // request capture and fetch step
   always_comb begin
      mode_in  = mode_ff;
      side_in  = side_ff;
      align_in = align_ff;
      size_in  = size_ff;
      if (ctrl.load) begin
         mode_in  = deaa_mode_type'(req_mode);
         side_in  = req_high_side;
         align_in = req_align_bytes;
         size_in  = req_size_bytes;
      end

      t_eff = (mode_ff == MODE_PUSH) ? 32'(cfg.mark) : size_ff;
      am1   = align_ff - ALIGN_W'(1);
      need  = 33'(t_eff) + ((align_ff == '0) ? 33'd0 : 33'(am1));

      teff_in = teff_ff;
      mask_in = mask_ff;
      fits_in = fits_ff;
      q_in    = q_ff;
      s_in    = s_ff;
      if (ctrl.step_fetch) begin
         teff_in = t_eff;
         mask_in = (align_ff > ALIGN_W'(1)) ? am1 : '0;
         fits_in = ({1'b0, free_ff} >= need);
         q_in    = high_addr_ff - ADDR_BITS'(t_eff) + ADDR_BITS'(1);
         s_in    = ALIGN_W'(low_addr_ff) + ((align_ff > ALIGN_W'(1)) ? am1 : '0);
      end
   end

   // align step: gap, aligned start, bytes taken, release gain
   always_comb begin
      off = side_ff ? (ALIGN_W'(q_ff) & mask_ff) : (mask_ff - (s_ff & mask_ff));

      pal_in      = pal_ff;
      tot_in      = tot_ff;
      ent_addr_in = ent_addr_ff;
      ent_used_in = ent_used_ff;
      gain_in     = gain_ff;
      if (ctrl.step_align) begin
         pal_in      = side_ff ? (q_ff - ADDR_BITS'(off)) : (low_addr_ff + ADDR_BITS'(off));
         tot_in      = 33'(teff_ff) + 33'(off);
         ent_addr_in = ram_rd_data.addr;
         ent_used_in = ram_rd_data.used;
         if (cnt_zero) begin
            gain_in = used_sel;
         end else if (used_sel > ram_rd_data.used) begin
            gain_in = used_sel - ram_rd_data.used;
         end else begin
            gain_in = 32'd0;
         end
      end
   end

   // commit and report steps
   always_comb begin
      low_addr_in  = low_addr_ff;
      high_addr_in = high_addr_ff;
      free_in      = free_ff;
      low_used_in  = low_used_ff;
      high_used_in = high_used_ff;
      low_cnt_in   = low_cnt_ff;
      high_cnt_in  = high_cnt_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;

      rsp_valid_in     = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_address_in   = rsp_address_ff;
      rsp_remaining_in = rsp_remaining_ff;
      rsp_all_free_in  = rsp_all_free_ff;

      if (ctrl.step_commit) begin
         status_in = STAT_DONE;
         addr_in   = 32'd0;
         case (mode_ff)
            MODE_ALLOC, MODE_PUSH: begin
               if ((mode_ff == MODE_PUSH) && cnt_full) begin
                  status_in = STAT_STACK_FULL;
               end else if (!fits_ff) begin
                  status_in = STAT_NO_SPACE;
               end else begin
                  addr_in = 32'(pal_ff);
                  free_in = free_ff - 32'(tot_ff);
                  if (side_ff) begin
                     high_addr_in = pal_ff - ADDR_BITS'(1);
                     high_used_in = sat_add32(high_used_ff, 32'(tot_ff));
                     if (mode_ff == MODE_PUSH) high_cnt_in = high_cnt_ff + CNT_W'(1);
                  end else begin
                     low_addr_in = pal_ff + ADDR_BITS'(teff_ff);
                     low_used_in = sat_add32(low_used_ff, 32'(tot_ff));
                     if (mode_ff == MODE_PUSH) low_cnt_in = low_cnt_ff + CNT_W'(1);
                  end
               end
            end
            MODE_RELEASE: begin
               free_in = sat_add32(free_ff, gain_ff);
               if (side_ff) begin
                  if (cnt_zero) begin
                     high_used_in = 32'd0;
                     high_addr_in = init_high_ff;
                  end else begin
                     high_cnt_in  = high_cnt_ff - CNT_W'(1);
                     high_used_in = ent_used_ff;
                     high_addr_in = ent_addr_ff + ADDR_BITS'(cfg.mark) - ADDR_BITS'(1);
                  end
               end else begin
                  if (cnt_zero) begin
                     low_used_in = 32'd0;
                     low_addr_in = init_low_ff;
                  end else begin
                     low_cnt_in  = low_cnt_ff - CNT_W'(1);
                     low_used_in = ent_used_ff;
                     low_addr_in = ent_addr_ff;
                  end
               end
            end
            default: status_in = STAT_DONE;
         endcase
      end

      if (ctrl.step_report) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = status_ff;
         rsp_address_in  = addr_ff;
         // judged on the state before a check reinitializes it
         rsp_all_free_in = ({1'b0, cfg.size} == ({1'b0, free_ff} + 33'(cfg.header)));
         rsp_remaining_in = free_ff;
         if (mode_ff == MODE_CHECK) begin
            rsp_remaining_in = init_free_ff;
            low_addr_in      = init_low_ff;
            high_addr_in     = init_high_ff;
            free_in          = init_free_ff;
            low_used_in      = 32'd0;
            high_used_in     = 32'd0;
            low_cnt_in       = '0;
            high_cnt_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_addr_ff  <= RST_LOW_ADDR;
         high_addr_ff <= RST_HIGH_ADDR;
         free_ff      <= RST_FREE;
         low_used_ff  <= 32'd0;
         high_used_ff <= 32'd0;
         low_cnt_ff   <= '0;
         high_cnt_ff  <= '0;
         init_low_ff  <= RST_LOW_ADDR;
         init_high_ff <= RST_HIGH_ADDR;
         init_free_ff <= RST_FREE;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_addr_ff  <= low_addr_in;
         high_addr_ff <= high_addr_in;
         free_ff      <= free_in;
         low_used_ff  <= low_used_in;
         high_used_ff <= high_used_in;
         low_cnt_ff   <= low_cnt_in;
         high_cnt_ff  <= high_cnt_in;
         init_low_ff  <= init_low_in;
         init_high_ff <= init_high_in;
         init_free_ff <= init_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      side_ff          <= side_in;
      align_ff         <= align_in;
      size_ff          <= size_in;
      teff_ff          <= teff_in;
      mask_ff          <= mask_in;
      fits_ff          <= fits_in;
      q_ff             <= q_in;
      s_ff             <= s_in;
      pal_ff           <= pal_in;
      tot_ff           <= tot_in;
      ent_addr_ff      <= ent_addr_in;
      ent_used_ff      <= ent_used_in;
      gain_ff          <= gain_in;
      status_ff        <= status_in;
      addr_ff          <= addr_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_address_ff   <= rsp_address_in;
      rsp_remaining_ff <= rsp_remaining_in;
      rsp_all_free_ff  <= rsp_all_free_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_address   = rsp_address_ff;
   assign rsp_remaining = rsp_remaining_ff;
   assign rsp_all_free  = rsp_all_free_ff;

endmodule
`default_nettype wire

// ----- hdl/double_ended_arena_allocator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_arena_allocator_unit
// Arena allocator filled from both ends, with per-side mark stacks in RAM.
// ----------------------------------------------------------------------------
// sequence: an accepted request passes the fetch, align, commit and report
//   steps in order; rsp_valid is registered from the report step
// a new request is taken only in idle, after the report step; the mark stack
//   RAM read and the alignment arithmetic each take a step of the sequence
// reset: synchronous; registers take their reset values and the arena is set
//   up from them at once, no clearing pass; results cannot be stalled
module double_ended_arena_allocator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic        req_high_side,
   input  wire logic [16:0] req_align_bytes,
   input  wire logic [31:0] req_size_bytes,
   output      logic        rsp_valid,
   output      logic [1:0]  rsp_status,
   output      logic [31:0] rsp_address,
   output      logic [31:0] rsp_remaining,
   output      logic        rsp_all_free,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [deaa_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);
   import deaa_pkg::*;

   deaa_cfg_type  cfg_ff, cfg_in;
   deaa_ctrl_type ctrl;
   deaa_reg_type  reg_sel;
   logic          wr_beat;

   assign pready  = 1'b1;
   assign reg_sel = deaa_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_beat = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         case (reg_sel)
            REG_ARENA_BASE: cfg_in.base   = pwdata;
            REG_ARENA_SIZE: cfg_in.size   = pwdata;
            REG_HEADER:     cfg_in.header = pwdata[11:0];
            REG_MARK:       cfg_in.mark   = pwdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_ARENA_BASE: prdata = cfg_ff.base;
         REG_ARENA_SIZE: prdata = cfg_ff.size;
         REG_HEADER:     prdata = 32'(cfg_ff.header);
         REG_MARK:       prdata = 32'(cfg_ff.mark);
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{base: RST_BASE, size: RST_SIZE, header: RST_HEADER, mark: RST_MARK};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   deaa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   deaa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .cfg             (cfg_ff),
      .req_mode        (req_mode),
      .req_high_side   (req_high_side),
      .req_align_bytes (req_align_bytes),
      .req_size_bytes  (req_size_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_address     (rsp_address),
      .rsp_remaining   (rsp_remaining),
      .rsp_all_free    (rsp_all_free)
   );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-ended arena allocator. Requests go in on
// the start/busy port with random gaps, the arena is reprogrammed over the
// APB port between phases, and every response beat is checked field by field
// against a local model of both sides, their mark stacks and the free count.
// ----------------------------------------------------------------------------

import deaa_pkg::*;

localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;
localparam logic [63:0] COUNT_MAX = 64'hFFFF_FFFF;

class arena_scoreboard;
   typedef struct {
      deaa_status_type status;
      logic [31:0]     address;
      logic [31:0]     remaining;
      logic            all_free;
   } arena_result_type;

   // register copies, live as the block sees them
   logic [63:0] reg_base, reg_size, reg_header, reg_mark;

   logic [63:0] side_ptr [2];
   logic [63:0] side_used [2];
   logic [63:0] avail;
   logic [63:0] frame_addr [2][MARK_DEPTH];
   logic [63:0] frame_used [2][MARK_DEPTH];
   int unsigned frame_cnt [2];

   arena_result_type pending_results [$];
   int unsigned failures, checked, taken, granted, short_space, stack_full;

   function new();
      reg_base    = 64'(RST_BASE);
      reg_size    = 64'(RST_SIZE);
      reg_header  = 64'(RST_HEADER);
      reg_mark    = 64'(RST_MARK);
      failures    = 0;
      checked     = 0;
      taken       = 0;
      granted     = 0;
      short_space = 0;
      stack_full  = 0;
      reinit();
   endfunction

   function void complain(string msg);
      failures++;
      if (failures <= 10)
         $display("mismatch: %s", msg);
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   function void set_register(deaa_reg_type idx, logic [31:0] value);
      case (idx)
         REG_ARENA_BASE: reg_base = 64'(value);
         REG_ARENA_SIZE: reg_size = 64'(value);
         REG_HEADER:     reg_header = 64'(value[11:0]);
         REG_MARK:       reg_mark = 64'(value[7:0]);
         default: ;
      endcase
   endfunction

   function logic [31:0] register_value(deaa_reg_type idx);
      case (idx)
         REG_ARENA_BASE: return reg_base[31:0];
         REG_ARENA_SIZE: return reg_size[31:0];
         REG_HEADER:     return reg_header[31:0];
         default:        return reg_mark[31:0];
      endcase
   endfunction

   function logic [63:0] sat32(logic [63:0] x, logic [63:0] y);
      logic [63:0] s;
      s = {32'd0, x[31:0]} + {32'd0, y[31:0]};
      return (s > COUNT_MAX) ? COUNT_MAX : s;
   endfunction

   function void reinit();
      side_ptr[0]  = (reg_base + reg_header) & ADDR_MASK;
      side_ptr[1]  = (reg_base + reg_size - 64'd1) & ADDR_MASK;
      avail        = (reg_size >= reg_header) ? reg_size - reg_header : 64'd0;
      side_used[0] = 64'd0;
      side_used[1] = 64'd0;
      frame_cnt[0] = 0;
      frame_cnt[1] = 0;
   endfunction

   // carve nbytes from one side; the alignment gap counts as used
   function bit try_grant(bit side, logic [63:0] align, logic [63:0] nbytes,
                          output logic [63:0] at);
      logic [63:0] need, mask, p, off;
      need = nbytes + ((align == 64'd0) ? 64'd0 : align - 64'd1);
      mask = (align > 64'd1) ? align - 64'd1 : 64'd0;
      at   = 64'd0;
      if (avail < need)
         return 1'b0;
      if (side) begin
         p           = (side_ptr[1] - nbytes + 64'd1) & ADDR_MASK;
         off         = p & mask;
         p           = (p - off) & ADDR_MASK;
         side_ptr[1] = (p - 64'd1) & ADDR_MASK;
      end else begin
         p           = side_ptr[0];
         off         = mask - ((p + mask) & mask);
         p           = (p + off) & ADDR_MASK;
         side_ptr[0] = (p + nbytes) & ADDR_MASK;
      end
      side_used[side] = sat32(side_used[side], nbytes + off);
      avail = avail - (nbytes + off);
      at    = p;
      return 1'b1;
   endfunction

   function void unwind(bit side);
      logic [63:0] m_addr, m_used;
      if (frame_cnt[side] == 0) begin
         // no mark: the whole side goes back to its home position
         avail           = sat32(avail, side_used[side]);
         side_used[side] = 64'd0;
         if (side)
            side_ptr[1] = (reg_base + reg_size - 64'd1) & ADDR_MASK;
         else
            side_ptr[0] = (reg_base + reg_header) & ADDR_MASK;
      end else begin
         frame_cnt[side]--;
         m_addr = frame_addr[side][frame_cnt[side]];
         m_used = frame_used[side][frame_cnt[side]];
         if (side_used[side] > m_used)
            avail = sat32(avail, side_used[side] - m_used);
         side_used[side] = m_used;
         if (side)
            side_ptr[1] = (m_addr + reg_mark - 64'd1) & ADDR_MASK;
         else
            side_ptr[0] = m_addr;
      end
   endfunction

   function void take_request(deaa_mode_type mode, bit side, logic [16:0] align,
                              logic [31:0] nbytes);
      arena_result_type r;
      logic [63:0] at, prior;
      r.status  = STAT_DONE;
      r.address = '0;
      case (mode)
         MODE_ALLOC: begin
            if (try_grant(side, 64'(align), 64'(nbytes), at))
               r.address = at[31:0];
            else
               r.status = STAT_NO_SPACE;
         end
         MODE_PUSH: begin
            prior = side_used[side];
            if (frame_cnt[side] >= MARK_DEPTH) begin
               r.status = STAT_STACK_FULL;
            end else if (!try_grant(side, 64'(align), reg_mark, at)) begin
               r.status = STAT_NO_SPACE;
            end else begin
               frame_addr[side][frame_cnt[side]] = at;
               frame_used[side][frame_cnt[side]] = prior;
               frame_cnt[side]++;
               r.address = at[31:0];
            end
         end
         MODE_RELEASE: unwind(side);
         default: ;
      endcase
      // a check judges emptiness before the arena is rebuilt
      r.all_free = (reg_size == avail + reg_header);
      if (mode == MODE_CHECK)
         reinit();
      r.remaining = avail[31:0];
      taken++;
      case (r.status)
         STAT_NO_SPACE:   short_space++;
         STAT_STACK_FULL: stack_full++;
         default: begin
            if (mode == MODE_ALLOC || mode == MODE_PUSH)
               granted++;
         end
      endcase
      pending_results.push_back(r);
   endfunction

   function void check_result(logic [1:0] status, logic [31:0] address,
                              logic [31:0] remaining, logic all_free);
      arena_result_type exp;
      checked++;
      if (pending_results.size() == 0) begin
         complain($sformatf("beat %0d arrived with nothing outstanding", checked));
         return;
      end
      exp = pending_results.pop_front();
      if (status !== exp.status || address !== exp.address ||
          remaining !== exp.remaining || all_free !== exp.all_free)
         complain($sformatf({"beat %0d: expected status %0d addr %h remaining %h ",
                             "all_free %0d, got %0d %h %h %0d"},
                            checked, exp.status, exp.address, exp.remaining,
                            exp.all_free, status, address, remaining, all_free));
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 250000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = '0;
   logic        req_high_side = 1'b0;
   logic [16:0] req_align_bytes = '0;
   logic [31:0] req_size_bytes = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_address;
   logic [31:0] rsp_remaining;
   logic        rsp_all_free;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   arena_scoreboard sb;
   int unsigned     cycle_count = 0;
   int unsigned     settings_used = 0;
   bit              steady = 1'b0;
   logic [31:0]     cur_size = RST_SIZE;

   double_ended_arena_allocator_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_high_side   (req_high_side),
      .req_align_bytes (req_align_bytes),
      .req_size_bytes  (req_size_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_address     (rsp_address),
      .rsp_remaining   (rsp_remaining),
      .rsp_all_free    (rsp_all_free),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_status, rsp_address, rsp_remaining, rsp_all_free);
   end

   function automatic logic [16:0] rand_align();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         return 17'($urandom_range(0, 1));
      else if (pick < 75)
         return 17'd1 << $urandom_range(1, 6);
      else if (pick < 88)
         return 17'd1 << $urandom_range(7, 16);
      return 17'($urandom_range(0, 65536));
   endfunction

   function automatic logic [31:0] rand_size();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return $urandom_range(0, 48);
      else if (pick < 80)
         return $urandom_range(0, 512);
      else if (pick < 92)
         return $urandom_range(0, cur_size >> 3);
      else if (pick < 97)
         return $urandom;
      return $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
   endfunction

   // start stays high from one beat to the next unless a gap is inserted
   task automatic issue(deaa_mode_type mode, bit side, logic [16:0] align,
                        logic [31:0] nbytes);
      if (!steady && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= mode;
      req_high_side   <= side;
      req_align_bytes <= align;
      req_size_bytes  <= nbytes;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.take_request(mode, side, align, nbytes);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || busy) @(posedge clock);
   endtask

   task automatic csr_xfer(bit write, deaa_reg_type idx, logic [31:0] wdata,
                           output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_register(deaa_reg_type idx, logic [31:0] value);
      logic [31:0] readback;
      csr_xfer(1'b1, idx, value, readback);
      sb.set_register(idx, value);
      csr_xfer(1'b0, idx, 32'd0, readback);
      if (readback !== sb.register_value(idx))
         sb.complain($sformatf("register %0d read %h, expected %h",
                               idx, readback, sb.register_value(idx)));
   endtask

   // the arena is rebuilt from the new register values at the check that follows
   task automatic apply_setting(logic [31:0] base, logic [31:0] size,
                                logic [31:0] header, logic [31:0] mark);
      drain();
      write_register(REG_ARENA_BASE, base);
      write_register(REG_ARENA_SIZE, size);
      write_register(REG_HEADER, header);
      write_register(REG_MARK, mark);
      cur_size = size;
      settings_used++;
      issue(MODE_CHECK, 1'($urandom_range(0, 1)), rand_align(), $urandom);
   endtask

   task automatic random_phase(int quota);
      int  sent;
      int  kind;
      int  n;
      bit  side;
      sent = 0;
      while (sent < quota) begin
         kind = $urandom_range(0, 99);
         side = 1'($urandom_range(0, 1));
         if (kind < 55) begin
            // mark, a few blocks, then back to the mark
            issue(MODE_PUSH, side, rand_align(), $urandom);
            n = $urandom_range(1, 4);
            repeat (n) begin
               issue(MODE_ALLOC, ($urandom_range(0, 3) == 0) ? !side : side,
                     rand_align(), rand_size());
            end
            issue(MODE_RELEASE, side, rand_align(), $urandom);
            sent += n + 2;
         end else if (kind < 63) begin
            // run one mark stack past full, then unwind it all
            repeat (MARK_DEPTH + 1)
               issue(MODE_PUSH, side, 17'($urandom_range(0, 1)), $urandom);
            repeat (MARK_DEPTH + 1)
               issue(MODE_RELEASE, side, rand_align(), $urandom);
            sent += 2 * (MARK_DEPTH + 1);
         end else if (kind < 93) begin
            issue(deaa_mode_type'($urandom_range(0, 3)), side, rand_align(), rand_size());
            sent++;
         end else begin
            issue(MODE_CHECK, side, rand_align(), $urandom);
            sent++;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // directed: reset arena of 64 KiB, 64-byte header, 16-byte marks
      issue(MODE_ALLOC, 1'b0, 17'd0, 32'd0);
      issue(MODE_ALLOC, 1'b0, 17'd64, 32'd100);
      issue(MODE_ALLOC, 1'b0, 17'd3, 32'd5);
      issue(MODE_ALLOC, 1'b1, 17'd4096, 32'd100);
      issue(MODE_ALLOC, 1'b1, 17'd65536, 32'hFFFF_FFFF);
      issue(MODE_PUSH, 1'b0, 17'd1, 32'd0);
      issue(MODE_PUSH, 1'b1, 17'd16, 32'd0);
      issue(MODE_ALLOC, 1'b0, 17'd8, 32'd200);
      issue(MODE_ALLOC, 1'b1, 17'd0, 32'd1);
      issue(MODE_RELEASE, 1'b0, 17'd0, 32'd0);
      issue(MODE_RELEASE, 1'b0, 17'd0, 32'd0);
      issue(MODE_RELEASE, 1'b1, 17'd0, 32'd0);
      issue(MODE_RELEASE, 1'b1, 17'd0, 32'd0);
      issue(MODE_CHECK, 1'b0, 17'd0, 32'd0);
      issue(MODE_ALLOC, 1'b0, 17'd1, 32'd65472);
      issue(MODE_ALLOC, 1'b1, 17'd0, 32'd1);
      issue(MODE_PUSH, 1'b0, 17'd0, 32'd0);
      issue(MODE_CHECK, 1'b1, 17'd0, 32'd0);
      issue(MODE_ALLOC, 1'b1, 17'd32768, 32'd1);
      issue(MODE_ALLOC, 1'b0, 17'd65536, 32'd0);
      issue(MODE_RELEASE, 1'b1, 17'd0, 32'd0);
      issue(MODE_CHECK, 1'b0, 17'd0, 32'd0);

      apply_setting(RST_BASE, RST_SIZE, RST_HEADER, RST_MARK);
      random_phase(46);
      apply_setting(32'h0000_1000, 32'h0000_4000, 32'd0, 32'd1);
      random_phase(46);
      // arena wraps past the top of the address space
      apply_setting(32'hFFFF_F000, 32'h0000_3000, 32'd4095, 32'd255);
      random_phase(46);
      apply_setting(32'h0000_0000, 32'hFFFF_FFFF, 32'd0, 32'd8);
      random_phase(46);
      // header bigger than the arena and marks that take no space
      apply_setting(32'h8000_0000, 32'd0, 32'd100, 32'd0);
      random_phase(46);
      repeat (2) begin
         apply_setting($urandom & 32'hFFFF_F000, $urandom_range(1, 32) << 12,
                       $urandom_range(0, 4095), $urandom_range(1, 255));
         random_phase(46);
      end
      steady = 1'b1;
      apply_setting($urandom, $urandom_range(0, 32'h0010_0000),
                    $urandom_range(0, 4095), $urandom_range(0, 255));
      random_phase(46);

      drain();
      repeat (12) @(posedge clock);
      if (sb.pending() != 0)
         sb.complain($sformatf("%0d expected beats never arrived", sb.pending()));
      $display("%0d requests over %0d arena settings: %0d granted,",
               sb.taken, settings_used, sb.granted);
      $display("%0d short of space, %0d on a full mark stack, %0d beats checked",
               sb.short_space, sb.stack_full, sb.checked);
      $display("%0d mismatches", sb.failures);
      if (sb.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

// ----- filelist.f -----
hdl/deaa_pkg.sv
hdl/deaa_ram.sv
hdl/deaa_ctrl.sv
hdl/deaa_datapath.sv
hdl/double_ended_arena_allocator_unit.sv
dv/tb.sv
